### hdl/wssm_pkg.sv
// package: widths, codes and shared types of the working set size meter
`default_nettype none
package wssm_pkg;
	localparam int ADDR_W = 48;
	localparam int LEN_W = 8;
	localparam int PAGE_W = 44;
	localparam int PSIZE_W = 33;
	localparam int SKIP_W = 32;
	localparam int WLEN_W = 12;
	localparam int COUNT_W = 13;
	localparam int EPOCH_W = 8;
	localparam int CFG_DATA_W = 33;
	localparam int CFG_IDX_W = 2;
	localparam int PSIZE_MIN = 16;
	localparam int PSIZE_RESET = 4096;
	localparam int WLEN_RESET = 1000;
	localparam int COUNT_MAX = 8191;
	localparam int WINDOW_MAX_DEF = 2048;
	localparam int TABLE_SLOTS_DEF = 4096;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SKIP = 2'd0,
		REG_PAGE_SIZE = 2'd1,
		REG_WINDOW = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV_PAGE,
		ST_ISSUE,
		ST_PROBE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic done;
		logic [ADDR_W-1:0] quo;
	} div_res_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [PAGE_W-1:0] page;
	} slot_word_t;
endpackage
`default_nettype wire

### hdl/wssm_in_if.sv
// interface: reference word channel
`default_nettype none
interface wssm_in_if;
	logic valid;
	logic ready;
	logic [wssm_pkg::ADDR_W-1:0] address;
	logic [wssm_pkg::LEN_W-1:0] length;
	modport source (output valid, output address, output length, input ready);
	modport sink (input valid, input address, input length, output ready);
endinterface
`default_nettype wire

### hdl/wssm_out_if.sv
// interface: result word channel
`default_nettype none
interface wssm_out_if;
	logic valid;
	logic ready;
	logic [wssm_pkg::COUNT_W-1:0] working_set_size;
	modport source (output valid, output working_set_size, input ready);
	modport sink (input valid, input working_set_size, output ready);
endinterface
`default_nettype wire

### hdl/working_set_size_meter.sv
// top level: working set size meter
//
//  channel  | dir | word fields             | handshake
//  refs     | in  | address, length         | valid/ready
//  result   | out | working_set_size        | valid/ready
//  cfg      | in  | cfg_idx, cfg_data       | cfg_we, no wait
//
// a skipped reference is only counted off; a counted one has its pages found by division
// in two bit-serial dividers side by side, then a linear probe of the slot ram, one slot
// a cycle, for each page, with a further issue step when it spans two pages. the slot is
// the low page bits, so the user must give the table a power of two of slots; the block
// itself does not enforce it. window end waits while an earlier result is still untaken.
// after reset, and every 255 windows when the epoch mark wraps, a clearing pass sweeps
// every slot of the ram and no reference is accepted.
`default_nettype none
module working_set_size_meter #(
	parameter int WINDOW_MAX = wssm_pkg::WINDOW_MAX_DEF,
	parameter int TABLE_SLOTS = wssm_pkg::TABLE_SLOTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	wssm_in_if.sink refs,
	wssm_out_if.source result,
	input wire logic cfg_we,
	input wire logic [wssm_pkg::CFG_IDX_W-1:0] cfg_idx,
	input wire logic [wssm_pkg::CFG_DATA_W-1:0] cfg_data
);
	localparam int SLOT_W = $clog2(TABLE_SLOTS);
	localparam int TRY_W = $clog2(TABLE_SLOTS + 1);
	localparam int POS_W = $clog2(WINDOW_MAX + 1);
	localparam int CMP_W = (POS_W > wssm_pkg::WLEN_W) ? POS_W : wssm_pkg::WLEN_W;
	localparam int WORD_W = $bits(wssm_pkg::slot_word_t);
	localparam int AW = wssm_pkg::ADDR_W;
	localparam int PW = wssm_pkg::PAGE_W;
	localparam int CW = wssm_pkg::COUNT_W;
	localparam int EW = wssm_pkg::EPOCH_W;

	wssm_pkg::state_t state_q, state_d;

	logic [wssm_pkg::SKIP_W-1:0] skip_q;
	logic [wssm_pkg::PSIZE_W-1:0] psize_q;
	logic [wssm_pkg::WLEN_W-1:0] wlen_q;

	logic [wssm_pkg::SKIP_W-1:0] skipped_q, skipped_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [CW-1:0] count_q, count_d;
	logic [EW-1:0] epoch_q, epoch_d;
	logic [SLOT_W-1:0] clr_q, clr_d;
	logic [PW-1:0] last_q, last_d, page_q, page_d;
	logic [SLOT_W-1:0] slot_q, slot_d, slot2_q, slot2_d;
	logic [TRY_W-1:0] tries_q, tries_d;
	logic second_q, second_d;
	logic out_v_q, out_v_d;
	logic [CW-1:0] out_data_q, out_data_d;

	logic div_start;
	logic [AW-1:0] div_a_in, div_b_in;
	logic [wssm_pkg::PSIZE_W-1:0] div_divisor;
	wssm_pkg::div_res_t res_a, res_b;

	logic ram_we;
	logic [SLOT_W-1:0] ram_waddr, ram_raddr;
	wssm_pkg::slot_word_t ram_wdata, ram_rdata;

	logic [wssm_pkg::PSIZE_W-1:0] psize_eff;
	logic [CMP_W-1:0] window_eff;
	logic [AW-1:0] last_addr;
	logic [POS_W-1:0] pos_inc;
	logic page_done;
	logic [TRY_W-1:0] tries_inc;

	wssm_div u_div_a (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_a_in), .divisor(div_divisor), .res(res_a)
	);
	wssm_div u_div_b (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_b_in), .divisor(div_divisor), .res(res_b)
	);

	wssm_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_SLOTS)) u_slots (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= '0;
			psize_q <= wssm_pkg::PSIZE_W'(wssm_pkg::PSIZE_RESET);
			wlen_q <= wssm_pkg::WLEN_W'(wssm_pkg::WLEN_RESET);
		end else if (cfg_we) begin
			case (wssm_pkg::cfg_reg_t'(cfg_idx))
				wssm_pkg::REG_SKIP: skip_q <= cfg_data[wssm_pkg::SKIP_W-1:0];
				wssm_pkg::REG_PAGE_SIZE: psize_q <= cfg_data;
				wssm_pkg::REG_WINDOW: wlen_q <= cfg_data[wssm_pkg::WLEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign psize_eff = (psize_q < wssm_pkg::PSIZE_W'(wssm_pkg::PSIZE_MIN))
		? wssm_pkg::PSIZE_W'(wssm_pkg::PSIZE_MIN) : psize_q;
	assign window_eff = (wlen_q == '0) ? CMP_W'(1)
		: (CMP_W'(wlen_q) > CMP_W'(WINDOW_MAX)) ? CMP_W'(WINDOW_MAX) : CMP_W'(wlen_q);
	assign last_addr = refs.address
		+ AW'((refs.length == '0) ? wssm_pkg::LEN_W'(1) : refs.length) - AW'(1);
	assign pos_inc = pos_q + 1'b1;
	assign tries_inc = tries_q + 1'b1;

	assign refs.ready = (state_q == wssm_pkg::ST_IDLE);
	assign result.valid = out_v_q;
	assign result.working_set_size = out_data_q;

	always_comb begin
		state_d = state_q;
		skipped_d = skipped_q;
		pos_d = pos_q;
		count_d = count_q;
		epoch_d = epoch_q;
		clr_d = clr_q;
		last_d = last_q;
		page_d = page_q;
		slot_d = slot_q;
		slot2_d = slot2_q;
		tries_d = tries_q;
		second_d = second_q;
		out_v_d = out_v_q && !result.ready;
		out_data_d = out_data_q;
		div_start = 1'b0;
		div_a_in = refs.address;
		div_b_in = last_addr;
		div_divisor = psize_eff;
		ram_we = 1'b0;
		ram_waddr = slot_q;
		ram_wdata.epoch = epoch_q;
		ram_wdata.page = page_q;
		ram_raddr = slot_q;
		page_done = 1'b0;
		case (state_q)
			wssm_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				ram_wdata.epoch = '0;
				ram_wdata.page = '0;
				clr_d = clr_q + 1'b1;
				if (clr_q == SLOT_W'(TABLE_SLOTS - 1)) begin
					clr_d = '0;
					epoch_d = EW'(1);
					state_d = wssm_pkg::ST_IDLE;
				end
			end
			wssm_pkg::ST_IDLE: begin
				if (refs.valid) begin
					if (skipped_q < skip_q) begin
						skipped_d = skipped_q + 1'b1;
					end else begin
						div_start = 1'b1;
						state_d = wssm_pkg::ST_DIV_PAGE;
					end
				end
			end
			wssm_pkg::ST_DIV_PAGE: begin
				if (res_a.done) begin
					page_d = res_a.quo[PW-1:0];
					last_d = res_b.quo[PW-1:0];
					slot_d = res_a.quo[SLOT_W-1:0];
					slot2_d = res_b.quo[SLOT_W-1:0];
					second_d = (res_a.quo != res_b.quo);
					tries_d = '0;
					state_d = wssm_pkg::ST_ISSUE;
				end
			end
			wssm_pkg::ST_ISSUE: begin
				state_d = wssm_pkg::ST_PROBE;
			end
			wssm_pkg::ST_PROBE: begin
				if (ram_rdata.epoch != epoch_q) begin
					ram_we = 1'b1;
					if (count_q != CW'(wssm_pkg::COUNT_MAX)) begin
						count_d = count_q + 1'b1;
					end
					page_done = 1'b1;
				end else if (ram_rdata.page == page_q) begin
					page_done = 1'b1;
				end else if (tries_inc == TRY_W'(TABLE_SLOTS)) begin
					page_done = 1'b1;
				end else begin
					tries_d = tries_inc;
					slot_d = (slot_q == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : slot_q + 1'b1;
					ram_raddr = slot_d;
				end
				if (page_done) begin
					if (second_q) begin
						second_d = 1'b0;
						page_d = last_q;
						slot_d = slot2_q;
						tries_d = '0;
						state_d = wssm_pkg::ST_ISSUE;
					end else begin
						pos_d = pos_inc;
						state_d = (CMP_W'(pos_inc) >= window_eff)
							? wssm_pkg::ST_FINISH : wssm_pkg::ST_IDLE;
					end
				end
			end
			wssm_pkg::ST_FINISH: begin
				if (!out_v_q || result.ready) begin
					out_v_d = 1'b1;
					out_data_d = count_q;
					count_d = '0;
					pos_d = '0;
					if (epoch_q == '1) begin
						state_d = wssm_pkg::ST_CLEAR;
					end else begin
						epoch_d = epoch_q + 1'b1;
						state_d = wssm_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = wssm_pkg::ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wssm_pkg::ST_CLEAR;
			skipped_q <= '0;
			pos_q <= '0;
			count_q <= '0;
			epoch_q <= '0;
			clr_q <= '0;
			out_v_q <= 1'b0;
			second_q <= 1'b0;
			tries_q <= '0;
		end else begin
			state_q <= state_d;
			skipped_q <= skipped_d;
			pos_q <= pos_d;
			count_q <= count_d;
			epoch_q <= epoch_d;
			clr_q <= clr_d;
			out_v_q <= out_v_d;
			second_q <= second_d;
			tries_q <= tries_d;
		end
	end

	always_ff @(posedge clk) begin
		last_q <= last_d;
		page_q <= page_d;
		slot_q <= slot_d;
		slot2_q <= slot2_d;
		out_data_q <= out_data_d;
	end

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == wssm_pkg::ST_PROBE || state_q == wssm_pkg::ST_CLEAR))
		else $error("slot ram written outside probe or clear");
	a_epoch_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != wssm_pkg::ST_CLEAR) |-> (epoch_q != '0))
		else $error("epoch mark equals the cleared mark");
	a_tries_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wssm_pkg::ST_PROBE) |-> (tries_q < TRY_W'(TABLE_SLOTS)))
		else $error("probe ran past the table");
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(state_q == wssm_pkg::ST_FINISH))
		else $error("result raised outside window end");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_a.done |-> (state_q == wssm_pkg::ST_DIV_PAGE))
		else $error("divider finished while not awaited");
endmodule
`default_nettype wire

### hdl/wssm_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module wssm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### hdl/wssm_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module wssm_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [wssm_pkg::ADDR_W-1:0] dividend,
	input wire logic [wssm_pkg::PSIZE_W-1:0] divisor,
	output wssm_pkg::div_res_t res
);
	localparam int NW = wssm_pkg::ADDR_W;
	localparam int DW = wssm_pkg::PSIZE_W;
	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] div_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DW:0] trial;
	logic take;

	assign trial = {rem_q, quo_q[NW-1]};
	assign take = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], take};
			rem_q <= take ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
		end
	end

	assign res.done = done_q;
	assign res.quo = quo_q;
endmodule
`default_nettype wire
